/* rtl/core/ptw_pkg.sv */
// Shared types and constants of the periodic timing wheel.
package ptw_pkg;

    localparam int WHEEL_SLOTS = 16;
    localparam int MAX_TIMERS  = 32;
    localparam int SLOT_BITS   = $clog2(WHEEL_SLOTS);
    localparam int ID_W        = $clog2(MAX_TIMERS);
    localparam int LINK_W      = ID_W + 1;
    localparam int PERIOD_W    = 16;
    localparam int ROUND_W     = PERIOD_W - SLOT_BITS;
    localparam int TIME_W      = 32;
    localparam int KIND_W      = 2;

    localparam logic [LINK_W-1:0] NO_TIMER = LINK_W'(MAX_TIMERS);

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_ADDED   = 2'd0;
    localparam kind_t KIND_REFUSED = 2'd1;
    localparam kind_t KIND_FIRED   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_FIRE_RD,
        ST_FIRE_TB,
        ST_FIRE_WR,
        ST_RESP
    } ptw_state_t;

    typedef struct packed {
        logic                link_en;
        logic [ID_W-1:0]     link_addr;
        logic [LINK_W-1:0]   link_data;
        logic                rnd_en;
        logic [ID_W-1:0]     rnd_addr;
        logic [ROUND_W-1:0]  rnd_data;
        logic                per_en;
        logic [PERIOD_W-1:0] per_data;
    } ptw_wr_t;

    typedef struct packed {
        logic [LINK_W-1:0]   link;
        logic [PERIOD_W-1:0] period;
        logic [ROUND_W-1:0]  rounds;
    } ptw_rd_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] fire_time;
        logic              last;
    } ptw_res_t;

endpackage

/* rtl/core/ptw_table.sv */
// Per-timer storage: next link, period and rounds left, with registered reads.
module ptw_table
    import ptw_pkg::*;
(
    input  logic            aclk,
    input  logic            rd_en,
    input  logic [ID_W-1:0] rd_addr,
    input  ptw_wr_t         wr,
    output ptw_rd_t         rd
);

    logic [LINK_W-1:0]   link_mem [MAX_TIMERS];
    logic [PERIOD_W-1:0] per_mem  [MAX_TIMERS];
    logic [ROUND_W-1:0]  rnd_mem  [MAX_TIMERS];

    always_ff @(posedge aclk) begin
        if (wr.link_en) begin
            link_mem[wr.link_addr] <= wr.link_data;
        end
        if (wr.rnd_en) begin
            rnd_mem[wr.rnd_addr] <= wr.rnd_data;
        end
        if (wr.per_en) begin
            per_mem[wr.rnd_addr] <= wr.per_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd.link   <= link_mem[rd_addr];
            rd.period <= per_mem[rd_addr];
            rd.rounds <= rnd_mem[rd_addr];
        end
    end

endmodule

/* rtl/core/ptw_ctrl.sv */
// Sequencer of the wheel: slot heads, add, slot walk and reinsertion of fired timers.
module ptw_ctrl
    import ptw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [PERIOD_W-1:0] s_period,
    input  logic [TIME_W-1:0]   s_tick_time,
    output logic                res_valid,
    input  logic                res_ready,
    output ptw_res_t            res,
    output logic                rd_en,
    output logic [ID_W-1:0]     rd_addr,
    output ptw_wr_t             wr,
    input  ptw_rd_t             rd
);

    ptw_state_t          state_reg, state_next;
    logic [TIME_W-1:0]   tick_reg;
    logic [LINK_W-1:0]   used_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [LINK_W-1:0]   cur_reg;
    logic [LINK_W-1:0]   prev_reg;
    logic [LINK_W-1:0]   nfired_reg;
    logic [LINK_W-1:0]   idx_reg;
    logic [ID_W-1:0]     fired_q_reg;
    logic [LINK_W-1:0]   head_reg [WHEEL_SLOTS];
    logic [ID_W-1:0]     fired_mem [MAX_TIMERS];
    ptw_res_t            res_reg;

    logic                 accept;
    logic                 refuse;
    logic [TIME_W-1:0]    tick_inc;
    logic [PERIOD_W-1:0]  place_period;
    logic [PERIOD_W-1:0]  place_pm1;
    logic [SLOT_BITS-1:0] place_slot;
    logic [ROUND_W-1:0]   place_rounds;
    logic [SLOT_BITS-1:0] head_idx;
    logic [LINK_W-1:0]    head_rd;
    logic                 head_we;
    logic [LINK_W-1:0]    head_wdata;
    logic                 due;
    logic                 fire_done;

    assign accept       = s_valid && s_ready;
    assign refuse       = (s_period == '0) || (used_reg == LINK_W'(MAX_TIMERS));
    assign tick_inc     = tick_reg + TIME_W'(1);
    assign due          = (rd.rounds == '0);
    assign fire_done    = (idx_reg == nfired_reg);

    // The one placement unit, shared by add and by reinsertion of fired timers.
    assign place_period = (state_reg == ST_FIRE_WR) ? rd.period : period_reg;
    assign place_pm1    = place_period - PERIOD_W'(1);
    assign place_slot   = tick_reg[SLOT_BITS-1:0] + place_period[SLOT_BITS-1:0];
    assign place_rounds = place_pm1[PERIOD_W-1:SLOT_BITS];

    always_comb begin
        unique case (state_reg)
            ST_IDLE:    head_idx = tick_inc[SLOT_BITS-1:0];
            ST_WALK_EV: head_idx = slot_reg;
            default:    head_idx = place_slot;
        endcase
    end
    assign head_rd = head_reg[head_idx];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_operation) begin
                        state_next = ST_WALK_RD;
                    end else if (refuse) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:     state_next = ST_RESP;
            ST_WALK_RD: state_next = cur_reg[ID_W] ? ST_FIRE_RD : ST_WALK_EV;
            ST_WALK_EV: state_next = ST_WALK_RD;
            ST_FIRE_RD: state_next = fire_done ? ST_IDLE : ST_FIRE_TB;
            ST_FIRE_TB: state_next = ST_FIRE_WR;
            ST_FIRE_WR: state_next = ST_RESP;
            ST_RESP: begin
                if (res_ready) begin
                    state_next = (res_reg.kind == KIND_FIRED) ? ST_FIRE_RD : ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = cur_reg[ID_W-1:0];
        wr         = '0;
        head_we    = 1'b0;
        head_wdata = rd.link;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_ADD: begin
                wr.link_en   = 1'b1;
                wr.link_addr = used_reg[ID_W-1:0];
                wr.link_data = head_rd;
                wr.rnd_en    = 1'b1;
                wr.rnd_addr  = used_reg[ID_W-1:0];
                wr.rnd_data  = place_rounds;
                wr.per_en    = 1'b1;
                wr.per_data  = period_reg;
                head_we      = 1'b1;
                head_wdata   = used_reg;
            end
            ST_WALK_RD: rd_en = !cur_reg[ID_W];
            ST_WALK_EV: begin
                if (due) begin
                    if (prev_reg[ID_W]) begin
                        head_we = 1'b1;
                    end else begin
                        wr.link_en   = 1'b1;
                        wr.link_addr = prev_reg[ID_W-1:0];
                        wr.link_data = rd.link;
                    end
                end else begin
                    wr.rnd_en   = 1'b1;
                    wr.rnd_addr = cur_reg[ID_W-1:0];
                    wr.rnd_data = rd.rounds - ROUND_W'(1);
                end
            end
            ST_FIRE_TB: begin
                rd_en   = 1'b1;
                rd_addr = fired_q_reg;
            end
            ST_FIRE_WR: begin
                wr.link_en   = 1'b1;
                wr.link_addr = fired_q_reg;
                wr.link_data = head_rd;
                wr.rnd_en    = 1'b1;
                wr.rnd_addr  = fired_q_reg;
                wr.rnd_data  = place_rounds;
                head_we      = 1'b1;
                head_wdata   = {1'b0, fired_q_reg};
            end
            ST_RESP: res_valid = 1'b1;
            default: s_ready = 1'b0;
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tick_reg   <= '0;
            used_reg   <= '0;
            nfired_reg <= '0;
            idx_reg    <= '0;
            for (int i = 0; i < WHEEL_SLOTS; i++) begin
                head_reg[i] <= NO_TIMER;
            end
        end else begin
            state_reg <= state_next;
            if (head_we) begin
                head_reg[head_idx] <= head_wdata;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && !s_operation) begin
                        tick_reg   <= tick_inc;
                        nfired_reg <= '0;
                    end
                end
                ST_ADD:     used_reg <= used_reg + LINK_W'(1);
                ST_WALK_RD: idx_reg  <= '0;
                ST_WALK_EV: begin
                    if (due) begin
                        nfired_reg <= nfired_reg + LINK_W'(1);
                    end
                end
                ST_RESP: begin
                    if (res_ready && (res_reg.kind == KIND_FIRED)) begin
                        idx_reg <= idx_reg + LINK_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    period_reg <= s_period;
                    time_reg   <= s_tick_time;
                    slot_reg   <= tick_inc[SLOT_BITS-1:0];
                    cur_reg    <= head_rd;
                    prev_reg   <= NO_TIMER;
                    res_reg    <= '{kind: KIND_REFUSED, id: '0, fire_time: '0, last: 1'b1};
                end
            end
            ST_ADD: begin
                res_reg <= '{kind: KIND_ADDED, id: used_reg[ID_W-1:0], fire_time: '0,
                             last: 1'b1};
            end
            ST_WALK_EV: begin
                if (due) begin
                    fired_mem[nfired_reg[ID_W-1:0]] <= cur_reg[ID_W-1:0];
                end else begin
                    prev_reg <= cur_reg;
                end
                cur_reg <= rd.link;
            end
            ST_FIRE_RD: fired_q_reg <= fired_mem[idx_reg[ID_W-1:0]];
            ST_FIRE_WR: begin
                res_reg <= '{kind: KIND_FIRED, id: fired_q_reg, fire_time: time_reg,
                             last: (idx_reg + LINK_W'(1)) == nfired_reg};
            end
            default: begin
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= LINK_W'(MAX_TIMERS))
        else $error("Timer count exceeds the table size.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        nfired_reg <= used_reg)
        else $error("More timers fired than exist.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_operation |=> tick_reg == $past(tick_inc))
        else $error("Tick count did not advance by one on a tick item.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIRE_TB || state_reg == ST_FIRE_WR) |-> idx_reg < nfired_reg)
        else $error("Reinsertion index ran past the fired list.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_operation && !refuse |=> ##1 used_reg == $past(used_reg, 2) + LINK_W'(1))
        else $error("An accepted add did not allocate one timer.");

endmodule

/* rtl/core/periodic_timing_wheel_top.sv */
// Top level of the periodic timing wheel with its result output register.
//
// The input channel (s_valid, s_ready) takes one item at a time: an add of a
// periodic timer (s_operation high, period in s_period) or one tick of time
// (s_operation low, timestamp in s_tick_time). The result channel
// (m_valid, m_ready) returns one item per result, with m_last on the last
// result of each input item. An add result passes through ST_ADD, ST_RESP and
// the output register to m_valid; a refused add skips ST_ADD. A tick walks the
// list of the slot it lands on, reading and then evaluating each timer in it,
// and reinserts each fired timer and hands it to the output; a tick with nothing
// due returns no result. The per-timer table has one read port, shared by the
// walk and the reinsertion. s_ready is high only while the block is idle, so the
// next item is taken right after the last result of the previous one leaves the
// sequencer. When the receiver stalls, the output register holds the result and
// the sequencer waits. Reset clears the tick count, the timer count and all slot
// heads; timer entries are written before they are ever read.
module periodic_timing_wheel_top
    import ptw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [PERIOD_W-1:0] s_period,
    input  logic [TIME_W-1:0]   s_tick_time,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KIND_W-1:0]   m_kind,
    output logic [ID_W-1:0]     m_timer_id,
    output logic [TIME_W-1:0]   m_fire_time,
    output logic                m_last
);

    logic            res_valid;
    logic            res_ready;
    ptw_res_t        res;
    logic            rd_en;
    logic [ID_W-1:0] rd_addr;
    ptw_wr_t         wr;
    ptw_rd_t         rd;
    logic            m_valid_reg;
    ptw_res_t        out_reg;

    ptw_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_period    (s_period),
        .s_tick_time (s_tick_time),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr          (wr),
        .rd          (rd)
    );

    ptw_table u_table (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd      (rd)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = out_reg.kind;
    assign m_timer_id  = out_reg.id;
    assign m_fire_time = out_reg.fire_time;
    assign m_last      = out_reg.last;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench of the periodic timing wheel, with its own wheel predictor.
`timescale 1ns / 1ps

module tb_top;
    import ptw_pkg::*;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;
    localparam int   CYCLE_LIMIT  = 1_000_000;
    localparam int   LONG_HOLD    = 400;
    localparam int   DRAIN_CYCLES = 300;

    typedef struct packed {
        logic                op;
        logic [PERIOD_W-1:0] per;
        logic [TIME_W-1:0]   stamp;
    } wheel_cmd_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_operation = 1'b0;
    logic [PERIOD_W-1:0] s_period    = '0;
    logic [TIME_W-1:0]   s_tick_time = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [KIND_W-1:0]   m_kind;
    logic [ID_W-1:0]     m_timer_id;
    logic [TIME_W-1:0]   m_fire_time;
    logic                m_last;

    wheel_cmd_t cmd_backlog[$];
    ptw_res_t   due_results[$];
    ptw_res_t   want_res;
    logic       took_item   = 1'b0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    logic       hold_req    = 1'b0;
    logic       hold_served = 1'b0;
    int         hold_left   = 0;
    int         cycle_count = 0;
    int         mismatches  = 0;
    int         items_taken = 0;
    int         results_seen = 0;
    int         fires_seen  = 0;
    int         refusals_seen = 0;
    int         adds_sent   = 0;

    logic [TIME_W-1:0]   wheel_count;
    logic [LINK_W-1:0]   slot_first [WHEEL_SLOTS];
    logic [LINK_W-1:0]   timer_next [MAX_TIMERS];
    logic [PERIOD_W-1:0] timer_per  [MAX_TIMERS];
    logic [ROUND_W-1:0]  timer_laps [MAX_TIMERS];
    int                  timers_alloc;

    periodic_timing_wheel_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_period    (s_period),
        .s_tick_time (s_tick_time),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_timer_id  (m_timer_id),
        .m_fire_time (m_fire_time),
        .m_last      (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void hang_timer(int id, logic [TIME_W-1:0] base);
        logic [TIME_W-1:0] due_at;
        int                slot;
        due_at = base + TIME_W'(timer_per[id]);
        slot = int'(due_at % WHEEL_SLOTS);
        timer_laps[id] = ROUND_W'((int'(timer_per[id]) - 1) / WHEEL_SLOTS);
        timer_next[id] = slot_first[slot];
        slot_first[slot] = LINK_W'(id);
    endfunction

    function automatic void wheel_apply(wheel_cmd_t cmd);
        ptw_res_t r;
        int       fired[$];
        int       slot;
        int       cur;
        int       prev;
        int       nxt;
        int       id;
        r = '0;
        r.last = 1'b1;
        if (cmd.op == OP_ADD) begin
            if (cmd.per == 0 || timers_alloc >= MAX_TIMERS) begin
                r.kind = KIND_REFUSED;
            end else begin
                id = timers_alloc;
                timers_alloc++;
                timer_per[id] = cmd.per;
                hang_timer(id, wheel_count);
                r.kind = KIND_ADDED;
                r.id = ID_W'(id);
            end
            due_results.push_back(r);
            return;
        end
        wheel_count = wheel_count + 1'b1;
        slot = int'(wheel_count % WHEEL_SLOTS);
        cur = int'(slot_first[slot]);
        prev = MAX_TIMERS;
        for (int guard = 0; guard < MAX_TIMERS && cur < MAX_TIMERS; guard++) begin
            nxt = int'(timer_next[cur]);
            if (timer_laps[cur] == 0 && fired.size() < MAX_TIMERS) begin
                if (prev == MAX_TIMERS) begin
                    slot_first[slot] = LINK_W'(nxt);
                end else begin
                    timer_next[prev] = LINK_W'(nxt);
                end
                fired.push_back(cur);
            end else begin
                if (timer_laps[cur] != 0) begin
                    timer_laps[cur] = timer_laps[cur] - 1'b1;
                end
                prev = cur;
            end
            cur = nxt;
        end
        foreach (fired[i]) begin
            hang_timer(fired[i], wheel_count);
            r.kind = KIND_FIRED;
            r.id = ID_W'(fired[i]);
            r.fire_time = cmd.stamp;
            r.last = (i == fired.size() - 1);
            due_results.push_back(r);
        end
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !took_item) begin
            s_valid <= 1'b1;
        end else if (cmd_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
            s_valid <= 1'b1;
            {s_operation, s_period, s_tick_time} <= cmd_backlog.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req && !hold_served) begin
            hold_served <= 1'b1;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        took_item <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            items_taken++;
            wheel_apply({s_operation, s_period, s_tick_time});
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_kind == KIND_FIRED) fires_seen++;
            if (m_kind == KIND_REFUSED) refusals_seen++;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d id %0d fire_time %0h last %0d",
                       m_kind, m_timer_id, m_fire_time, m_last);
                mismatches++;
            end else begin
                want_res = due_results.pop_front();
                if (m_kind !== want_res.kind) begin
                    $error("m_kind: expected %0d, got %0d", want_res.kind, m_kind);
                    mismatches++;
                end
                if (m_timer_id !== want_res.id) begin
                    $error("m_timer_id: expected %0d, got %0d", want_res.id, m_timer_id);
                    mismatches++;
                end
                if (m_fire_time !== want_res.fire_time) begin
                    $error("m_fire_time: expected %0h, got %0h",
                           want_res.fire_time, m_fire_time);
                    mismatches++;
                end
                if (m_last !== want_res.last) begin
                    $error("m_last: expected %0d, got %0d", want_res.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic queue_cmd(logic op, logic [PERIOD_W-1:0] per, logic [TIME_W-1:0] stamp);
        wheel_cmd_t cmd;
        cmd.op = op;
        cmd.per = per;
        cmd.stamp = stamp;
        if (op == OP_ADD && per != 0) adds_sent++;
        cmd_backlog.push_back(cmd);
    endtask

    task automatic queue_random(int count);
        int                  r;
        logic [PERIOD_W-1:0] per;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < ((adds_sent < MAX_TIMERS) ? 25 : 8)) begin
                r = $urandom_range(99);
                if (r < 5) begin
                    per = '0;
                end else if (r < 75) begin
                    per = PERIOD_W'($urandom_range(40, 1));
                end else if (r < 92) begin
                    per = PERIOD_W'($urandom_range(300, 41));
                end else begin
                    per = PERIOD_W'($urandom);
                end
                queue_cmd(OP_ADD, per, TIME_W'($urandom));
            end else begin
                queue_cmd(OP_TICK, PERIOD_W'($urandom), TIME_W'($urandom));
            end
        end
    endtask

    task automatic settle();
        while (cmd_backlog.size() != 0 || s_valid || due_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        wheel_count = '0;
        timers_alloc = 0;
        foreach (slot_first[i]) slot_first[i] = NO_TIMER;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 59;
        queue_cmd(OP_TICK, '0, '0);
        queue_cmd(OP_ADD, '0, '0);
        queue_cmd(OP_ADD, 16'd1, '1);
        queue_cmd(OP_TICK, '1, '1);
        queue_cmd(OP_ADD, 16'd16, '0);
        queue_cmd(OP_ADD, 16'd32, '0);
        queue_cmd(OP_ADD, 16'd17, '0);
        queue_cmd(OP_ADD, 16'hFFFF, '1);
        queue_cmd(OP_ADD, 16'd15, '0);
        queue_cmd(OP_TICK, '0, 32'hAAAA_5555);
        queue_cmd(OP_TICK, '0, 32'h5555_AAAA);
        for (int k = 0; k < 13; k++) begin
            queue_cmd(OP_TICK, '0, TIME_W'($urandom));
        end
        queue_random(130);
        settle();

        tx_idle_pct = 59;
        rx_idle_pct = 12;
        queue_random(150);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        queue_random(150);
        settle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d items (%0d timers requested) and %0d results:",
                 items_taken, adds_sent, results_seen);
        $display("%0d timer firings and %0d refused adds, with %0d mismatches.",
                 fires_seen, refusals_seen, mismatches);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
